[rtl/core/pressure_altimeter_fixed_point_macros.svh]
// assertion macros for the pressure altimeter core
`ifndef PRESSURE_ALTIMETER_FIXED_POINT_MACROS_SVH
`define PRESSURE_ALTIMETER_FIXED_POINT_MACROS_SVH

`ifndef SYNTHESIS
`define PALT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define PALT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PALT_ASSERT_NOW(lbl, ante, cons, msg)
`define PALT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/palt_pkg.sv]
// shared types, constants and coefficient table for the pressure altimeter
package palt_pkg;

	localparam logic signed [15:0] REF_RESET  = 16'sd25331;
	localparam logic signed [15:0] C_F0       = 16'sd3132;
	localparam logic signed [15:0] C_CAL_M    = 16'sd7536;
	localparam logic signed [15:0] C_CAL_FT   = 16'sd12068;
	localparam logic signed [15:0] C_OUT_M    = 16'sd16869;
	localparam logic signed [15:0] C_OUT_FT   = 16'sd27672;
	localparam logic [16:0]        ONE_Q15    = 17'd32768;
	localparam logic [4:0]         DIV_LAST   = 5'd31;
	localparam logic [1:0]         K_LAST     = 2'd2;
	localparam logic               REG_METRIC_UNITS = 1'b0;
	localparam logic               METRIC_RESET     = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CAL_MUL,
		ST_CAL_EST,
		ST_F0_MUL,
		ST_F0_WB,
		ST_HF_MUL,
		ST_HF_WB,
		ST_FS_MUL,
		ST_FS_WB,
		ST_FF_MUL,
		ST_FF_WB,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_DONE,
		ST_PC_MUL,
		ST_PC_WB,
		ST_EST_UPD,
		ST_OUT_MUL,
		ST_OUT_WB
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CAL_MUL,
		OP_CAL_EST,
		OP_F0_MUL,
		OP_F0_WB,
		OP_HF_MUL,
		OP_HF_WB,
		OP_FS_MUL,
		OP_FS_WB,
		OP_FF_MUL,
		OP_FF_WB,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_PC_MUL,
		OP_PC_WB,
		OP_EST_UPD,
		OP_OUT_MUL,
		OP_RES
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] k;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	// series coefficients after the first term
	function automatic logic signed [15:0] coef(input logic [1:0] k);
		logic signed [15:0] c;
		case (k)
			2'd0:    c = 16'sd7032;
			2'd1:    c = 16'sd13533;
			default: c = 16'sd26533;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/palt_ctrl.sv]
// sequencer for the altimeter: series steps, serial divide and result handoff
`include "pressure_altimeter_fixed_point_macros.svh"

module palt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            action,
	output logic            in_stall,
	input  palt_pkg::sts_t  sts,
	output palt_pkg::cmd_t  cmd
);

	palt_pkg::state_t state_q, state_nx;
	logic             action_q;
	logic [4:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= palt_pkg::ST_IDLE;
			action_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == palt_pkg::ST_IDLE && in_valid)
				action_q <= action;
			if (state_q == palt_pkg::ST_F0_WB || state_q == palt_pkg::ST_DIV_INIT)
				cnt_q <= '0;
			else if (state_q == palt_pkg::ST_FS_WB || state_q == palt_pkg::ST_DIV_STEP)
				cnt_q <= cnt_q + 5'd1;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd.op   = palt_pkg::OP_NONE;
		cmd.k    = cnt_q[1:0];
		in_stall = 1'b1;
		unique case (state_q)
			palt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op   = palt_pkg::OP_LOAD;
					state_nx = action ? palt_pkg::ST_CAL_MUL : palt_pkg::ST_F0_MUL;
				end
			end
			palt_pkg::ST_CAL_MUL: begin
				cmd.op   = palt_pkg::OP_CAL_MUL;
				state_nx = palt_pkg::ST_CAL_EST;
			end
			palt_pkg::ST_CAL_EST: begin
				cmd.op   = palt_pkg::OP_CAL_EST;
				state_nx = palt_pkg::ST_F0_MUL;
			end
			palt_pkg::ST_F0_MUL: begin
				cmd.op   = palt_pkg::OP_F0_MUL;
				state_nx = palt_pkg::ST_F0_WB;
			end
			palt_pkg::ST_F0_WB: begin
				cmd.op   = palt_pkg::OP_F0_WB;
				state_nx = palt_pkg::ST_HF_MUL;
			end
			palt_pkg::ST_HF_MUL: begin
				cmd.op   = palt_pkg::OP_HF_MUL;
				state_nx = palt_pkg::ST_HF_WB;
			end
			palt_pkg::ST_HF_WB: begin
				cmd.op   = palt_pkg::OP_HF_WB;
				state_nx = palt_pkg::ST_FS_MUL;
			end
			palt_pkg::ST_FS_MUL: begin
				cmd.op   = palt_pkg::OP_FS_MUL;
				state_nx = palt_pkg::ST_FS_WB;
			end
			palt_pkg::ST_FS_WB: begin
				cmd.op   = palt_pkg::OP_FS_WB;
				state_nx = (cnt_q[1:0] == palt_pkg::K_LAST) ? palt_pkg::ST_FF_MUL
				                                             : palt_pkg::ST_HF_MUL;
			end
			palt_pkg::ST_FF_MUL: begin
				cmd.op   = palt_pkg::OP_FF_MUL;
				state_nx = palt_pkg::ST_FF_WB;
			end
			palt_pkg::ST_FF_WB: begin
				cmd.op   = palt_pkg::OP_FF_WB;
				state_nx = action_q ? palt_pkg::ST_DIV_INIT : palt_pkg::ST_PC_MUL;
			end
			palt_pkg::ST_DIV_INIT: begin
				cmd.op   = palt_pkg::OP_DIV_INIT;
				state_nx = palt_pkg::ST_DIV_STEP;
			end
			palt_pkg::ST_DIV_STEP: begin
				cmd.op = palt_pkg::OP_DIV_STEP;
				if (cnt_q == palt_pkg::DIV_LAST)
					state_nx = palt_pkg::ST_DIV_DONE;
			end
			palt_pkg::ST_DIV_DONE: begin
				cmd.op   = palt_pkg::OP_DIV_DONE;
				state_nx = palt_pkg::ST_IDLE;
			end
			palt_pkg::ST_PC_MUL: begin
				cmd.op   = palt_pkg::OP_PC_MUL;
				state_nx = palt_pkg::ST_PC_WB;
			end
			palt_pkg::ST_PC_WB: begin
				cmd.op   = palt_pkg::OP_PC_WB;
				state_nx = palt_pkg::ST_EST_UPD;
			end
			palt_pkg::ST_EST_UPD: begin
				cmd.op   = palt_pkg::OP_EST_UPD;
				state_nx = palt_pkg::ST_OUT_MUL;
			end
			palt_pkg::ST_OUT_MUL: begin
				cmd.op   = palt_pkg::OP_OUT_MUL;
				state_nx = palt_pkg::ST_OUT_WB;
			end
			palt_pkg::ST_OUT_WB: begin
				// hold the product until the output register frees up
				if (!sts.out_busy) begin
					cmd.op   = palt_pkg::OP_RES;
					state_nx = palt_pkg::ST_IDLE;
				end
			end
			default: state_nx = palt_pkg::ST_IDLE;
		endcase
	end

	`PALT_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall, "input taken twice in a row")
	`PALT_ASSERT_NOW(a_res_measure_only, cmd.op == palt_pkg::OP_RES, !action_q, "result from calibrate")
	`PALT_ASSERT_NOW(a_res_free, cmd.op == palt_pkg::OP_RES, !sts.out_busy, "result overwrites pending output")

endmodule

[rtl/core/palt_dp.sv]
// altimeter datapath: shared 16x16 multiplier, series registers, serial divider, output register
`include "pressure_altimeter_fixed_point_macros.svh"

module palt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  palt_pkg::cmd_t      cmd,
	output palt_pkg::sts_t      sts,
	input  logic                metric,
	input  logic [16:0]         pressure_pa,
	input  logic signed [15:0]  reference_altitude,
	input  logic                out_stall,
	output logic                out_valid,
	output logic signed [15:0]  altitude
);

	logic signed [15:0] est_q, ref_q, p4_q, alt_q, f_q, hf_q, alt_out_q;
	logic signed [31:0] prod_q;
	logic [16:0]        d_q, rem_q;
	logic [31:0]        dq_q;
	logic               neg_q, out_valid_q;

	logic signed [15:0] a_op, b_op, p16, p15;
	logic               mul_en;
	logic [17:0]        pa_rnd;
	logic [16:0]        d_nx;
	logic [32:0]        nsum;
	logic [31:0]        num, mag;
	logic [17:0]        trial;
	logic               ge;
	logic [17:0]        trial_sub;

	assign p16 = prod_q[31:16];
	assign p15 = prod_q[30:15];

	// rounding to 4 Pa units, top code wraps negative
	assign pa_rnd = {1'b0, pressure_pa} + 18'd2;

	always_comb begin
		mul_en = 1'b1;
		a_op   = est_q;
		b_op   = palt_pkg::C_F0;
		unique case (cmd.op)
			palt_pkg::OP_CAL_MUL: begin
				a_op = alt_q;
				b_op = metric ? palt_pkg::C_CAL_M : palt_pkg::C_CAL_FT;
			end
			palt_pkg::OP_F0_MUL: b_op = palt_pkg::C_F0;
			palt_pkg::OP_HF_MUL: b_op = palt_pkg::coef(cmd.k);
			palt_pkg::OP_FS_MUL: begin
				a_op = hf_q;
				b_op = f_q;
			end
			palt_pkg::OP_FF_MUL: b_op = f_q;
			palt_pkg::OP_PC_MUL: begin
				a_op = ref_q;
				b_op = f_q;
			end
			palt_pkg::OP_OUT_MUL: b_op = metric ? palt_pkg::C_OUT_M : palt_pkg::C_OUT_FT;
			default: mul_en = 1'b0;
		endcase
	end

	// divider setup: d = 1 - F in q15, dividend = (p4 * 2^16 + d) >> 1
	assign d_nx = palt_pkg::ONE_Q15 - {f_q[15], f_q};
	assign nsum = {p4_q[15], p4_q, 16'h0000} + {16'h0000, d_nx};
	assign num  = nsum[32:1];
	assign mag  = num[31] ? (32'd0 - num) : num;

	// one restoring step per cycle
	assign trial     = {rem_q, dq_q[31]};
	assign ge        = trial >= {1'b0, d_q};
	assign trial_sub = trial - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= a_op * b_op;
		unique case (cmd.op)
			palt_pkg::OP_LOAD: begin
				p4_q  <= pa_rnd[17:2];
				alt_q <= reference_altitude;
			end
			palt_pkg::OP_F0_WB: f_q  <= p16;
			palt_pkg::OP_HF_WB: hf_q <= p16;
			palt_pkg::OP_FS_WB: f_q  <= hf_q - p15;
			palt_pkg::OP_FF_WB: f_q  <= est_q - p15;
			palt_pkg::OP_DIV_INIT: begin
				d_q   <= d_nx;
				neg_q <= num[31];
				dq_q  <= mag;
				rem_q <= '0;
			end
			palt_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? trial_sub[16:0] : trial[16:0];
				dq_q  <= {dq_q[30:0], ge};
			end
			palt_pkg::OP_PC_WB: hf_q <= ref_q - p15;
			palt_pkg::OP_RES:   alt_out_q <= metric ? p16 : p15;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q       <= '0;
			ref_q       <= palt_pkg::REF_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == palt_pkg::OP_CAL_EST)
				est_q <= metric ? ((alt_q <<< 2) - p16) : (alt_q + p16);
			else if (cmd.op == palt_pkg::OP_EST_UPD)
				est_q <= est_q - (p4_q - hf_q);
			if (cmd.op == palt_pkg::OP_DIV_DONE)
				ref_q <= neg_q ? (16'sd0 - $signed(dq_q[15:0])) : $signed(dq_q[15:0]);
			if (cmd.op == palt_pkg::OP_RES)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign altitude     = alt_out_q;

	`PALT_ASSERT_NOW(a_div_nonzero, cmd.op == palt_pkg::OP_DIV_STEP, d_q != 17'd0, "zero divisor")
	`PALT_ASSERT_NOW(a_rem_bound, cmd.op == palt_pkg::OP_DIV_STEP, rem_q < d_q, "remainder not below divisor")

endmodule

[rtl/core/pressure_altimeter_fixed_point.sv]
// Barometric altimeter with iterative estimate refinement.
// Input channel (in_valid/in_stall): action, pressure_pa, reference_altitude.
//   action 1 calibrates: sets the estimate from reference_altitude and derives
//   the sea-level reference pressure; no transaction comes out.
//   action 0 measures: corrects the estimate and emits one altitude transaction.
// Output channel (out_valid/out_stall): altitude, held in an output register.
// Configuration: APB register metric_units at address 0 (1 meters, 0 feet).
// A measure item runs the series, pressure correction, estimate update and
// output scaling, then reaches the result register; the next item can be taken
// in the cycle after that. A calibrate item runs the series and then the divider
// before it updates the reference pressure. Each shared 16x16 multiply and each
// writeback through the five-term series has its own state; calibrate adds a
// one-bit-per-cycle 32-step restoring divider. One item is in flight at a time;
// in_stall is low only while the sequencer is idle.
// A waiting result does not block the next input; a measure item whose
// result finds the output register still stalled waits in its last step.
// Reset clears the output valid flag, sets the estimate to 0, the reference
// pressure to 25331 (101325 Pa) and metric_units to 1.
module pressure_altimeter_fixed_point (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [16:0]         pressure_pa,
	input  logic signed [15:0]  reference_altitude,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  altitude
);

	logic           metric_q;
	logic           reg_hit;
	palt_pkg::cmd_t cmd;
	palt_pkg::sts_t sts;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == palt_pkg::REG_METRIC_UNITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			metric_q <= palt_pkg::METRIC_RESET;
		else if (psel && penable && pwrite && reg_hit)
			metric_q <= pwdata[0];
	end

	assign prdata = reg_hit ? {31'd0, metric_q} : 32'd0;

	palt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	palt_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.metric             (metric_q),
		.pressure_pa        (pressure_pa),
		.reference_altitude (reference_altitude),
		.out_stall          (out_stall),
		.out_valid          (out_valid),
		.altitude           (altitude)
	);

endmodule
